// ===== rtl/wsdf_pkg.sv =====
// Shared constants for the inbound deframer: length width, result kinds, header codes.
package wsdf_pkg;

    // Width of the payload length counter
    localparam int LENGTH_BITS = 64;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_PONG  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Header byte fields and codes
    localparam logic [7:0] MASK_BIT      = 8'h80;
    localparam logic [6:0] LEN_EXT16     = 7'd126;
    localparam logic [6:0] LEN_EXT64     = 7'd127;
    localparam logic [6:0] OP_LAST_DATA  = 7'd2;
    localparam logic [6:0] OP_PING       = 7'd9;

    // Header byte counts: last index of each multi-byte header field
    localparam logic [2:0] EXT16_LAST_IDX = 3'd1;
    localparam logic [2:0] EXT64_LAST_IDX = 3'd7;
    localparam logic [2:0] MASK_LAST_IDX  = 3'd3;

endpackage

// ===== rtl/websocket_inbound_deframer_core.sv =====
// Inbound frame parser: removes the header and unmasks payload of client frames.
//
// Usage: raw stream bytes enter on the input channel (i_valid / o_ready,
// byte on i_in_byte), one byte per transfer. Results leave on the output
// channel (o_valid / i_ready) as o_out_kind, o_out_byte and o_out_last:
// unmasked data payload bytes with the frame's final byte marked last,
// one pong request on the opcode byte of a ping, and one error result on
// a length byte whose mask bit is clear (parsing then restarts at an
// opcode byte). Header bytes and bytes of other control frames give no
// result.
// A byte taken on the input channel is held in the input register until the
// result register is free or being taken.
// Throughput: one byte per cycle while the receiver takes results; each byte
// passes through an input register and one state update into the result register.
// When the receiver stalls, the result register holds and the input
// register fills; o_ready drops only when both hold an item, and rises
// again in the cycle the receiver takes the result.
// Reset (synchronous, active low) empties both registers and returns the
// parser to waiting for an opcode byte.
module websocket_inbound_deframer_core
    import wsdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    typedef enum logic [2:0] {
        PH_OPCODE  = 3'd0,
        PH_LEN     = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    localparam int LB = LENGTH_BITS;

    // Input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;

    // Parser state
    t_phase          r_phase, n_phase;
    logic [2:0]      r_hcnt, n_hcnt;
    logic [LB-1:0]   r_rem, n_rem;
    logic [31:0]     r_key, n_key;
    logic [1:0]      r_mpos, n_mpos;
    logic            r_is_data, n_is_data;

    // Result register
    logic       r_out_vld;
    logic [1:0] r_out_kind;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       n_emit;
    logic [1:0] n_kind;
    logic [7:0] n_byte;
    logic       n_last;

    logic       w_adv;
    logic [6:0] w_low7;
    logic [7:0] w_key_byte;

    // Advance the input item when the result register is free or being taken
    assign w_adv   = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || w_adv;

    assign w_low7 = r_in_byte[6:0];

    // Select the mask key byte for the current payload position
    always_comb begin
        case (r_mpos)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    // Parse one byte
    always_comb begin
        n_phase   = r_phase;
        n_hcnt    = r_hcnt;
        n_rem     = r_rem;
        n_key     = r_key;
        n_mpos    = r_mpos;
        n_is_data = r_is_data;
        n_emit    = 1'b0;
        n_kind    = KIND_DATA;
        n_byte    = 8'd0;
        n_last    = 1'b0;
        case (r_phase)
            PH_LEN: begin
                n_hcnt = 3'd0;
                if ((r_in_byte & MASK_BIT) == 8'd0) begin
                    n_emit  = 1'b1;
                    n_kind  = KIND_ERROR;
                    n_phase = PH_OPCODE;
                end else if (w_low7 == LEN_EXT16) begin
                    n_rem   = '0;
                    n_phase = PH_EXT16;
                end else if (w_low7 == LEN_EXT64) begin
                    n_rem   = '0;
                    n_phase = PH_EXT64;
                end else begin
                    n_rem   = LB'(w_low7);
                    n_phase = PH_MASK;
                end
            end
            PH_EXT16, PH_EXT64: begin
                n_rem = {r_rem[LB-9:0], r_in_byte};
                if ((r_phase == PH_EXT16 && r_hcnt >= EXT16_LAST_IDX) ||
                    (r_phase == PH_EXT64 && r_hcnt >= EXT64_LAST_IDX)) begin
                    n_hcnt  = 3'd0;
                    n_phase = PH_MASK;
                end else begin
                    n_hcnt = r_hcnt + 3'd1;
                end
            end
            PH_MASK: begin
                n_key = {r_key[23:0], r_in_byte};
                if (r_hcnt >= MASK_LAST_IDX) begin
                    n_hcnt  = 3'd0;
                    n_mpos  = 2'd0;
                    n_phase = (r_rem != '0) ? PH_PAYLOAD : PH_OPCODE;
                end else begin
                    n_hcnt = r_hcnt + 3'd1;
                end
            end
            PH_PAYLOAD: begin
                if (r_is_data) begin
                    n_emit = 1'b1;
                    n_kind = KIND_DATA;
                    n_byte = r_in_byte ^ w_key_byte;
                    n_last = (r_rem == LB'(1));
                end
                n_mpos = r_mpos + 2'd1;
                if (r_rem != '0) begin
                    n_rem = r_rem - LB'(1);
                end
                if (r_rem == '0 || r_rem == LB'(1)) begin
                    n_phase = PH_OPCODE;
                end
            end
            default: begin
                n_is_data = (w_low7 <= OP_LAST_DATA);
                n_hcnt    = 3'd0;
                n_phase   = PH_LEN;
                if (w_low7 == OP_PING) begin
                    n_emit = 1'b1;
                    n_kind = KIND_PONG;
                end
            end
        endcase
    end

    // Hold the input item until it advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
        if (i_valid && o_ready) begin
            r_in_byte <= i_in_byte;
        end
    end

    // Update parser state on each advanced byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_OPCODE;
            r_hcnt    <= 3'd0;
            r_rem     <= '0;
            r_key     <= '0;
            r_mpos    <= 2'd0;
            r_is_data <= 1'b0;
        end else if (w_adv) begin
            r_phase   <= n_phase;
            r_hcnt    <= n_hcnt;
            r_rem     <= n_rem;
            r_key     <= n_key;
            r_mpos    <= n_mpos;
            r_is_data <= n_is_data;
        end
    end

    // Load or drain the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= n_emit;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
        if (w_adv && n_emit) begin
            r_out_kind <= n_kind;
            r_out_byte <= n_byte;
            r_out_last <= n_last;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_out_kind = r_out_kind;
    assign o_out_byte = r_out_byte;
    assign o_out_last = r_out_last;

endmodule

// ===== rtl/wsdf_checker.sv =====
// Port-level checker for the inbound deframer, bound to the top level.
module wsdf_checker
    import wsdf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_out_kind,
    input logic [7:0] o_out_byte,
    input logic       o_out_last
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_kind) &&
            $stable(o_out_byte) && $stable(o_out_last)))
        else $error("stalled result changed");

    // Kind stays within the defined codes
    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_kind == KIND_DATA || o_out_kind == KIND_PONG ||
            o_out_kind == KIND_ERROR))
        else $error("undefined result kind");

    // Zero byte and last on pong and error results
    a_ctrl_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_kind != KIND_DATA) |-> (o_out_byte == 8'd0 && !o_out_last))
        else $error("control result carries payload fields");

    // Accept input whenever no result is pending
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty result register");

    // Empty result register right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result pending after reset");

endmodule

bind websocket_inbound_deframer_core wsdf_checker u_wsdf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_out_kind (o_out_kind),
    .o_out_byte (o_out_byte),
    .o_out_last (o_out_last)
);
